// ===== rtl/sui_pkg.sv =====
package sui_pkg;

	// Default number of elements each store holds.
	localparam int DEPTH_DEF = 64;

	// Field widths.
	localparam int KIND_W      = 2;
	localparam int ELEM_W      = 32;
	localparam int SET_ID_W    = 2;
	localparam int UNION_CNT_W = 8;
	localparam int INTER_CNT_W = 13;

	// Saturation limits of the two running counts.
	localparam logic [UNION_CNT_W-1:0] UNION_MAX = '1;
	localparam logic [INTER_CNT_W-1:0] INTER_MAX = '1;

	// Entries of the command queue between front and engine (a power of two).
	localparam int QUEUE_DEPTH = 2;

	// Input kind codes.
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd1;
	localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PULL     = 2'd3;

	// Result set identifiers.
	localparam logic [SET_ID_W-1:0] ID_UNION   = 2'd0;
	localparam logic [SET_ID_W-1:0] ID_INTER   = 2'd1;
	localparam logic [SET_ID_W-1:0] ID_SUMMARY = 2'd2;

	// Commands after classification by the front.
	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_APPEND_A = 2'd1,
		OP_APPEND_B = 2'd2,
		OP_PULL     = 2'd3
	} op_t;

	// Head of the command queue as seen by the engine.
	typedef struct packed {
		logic                     valid;
		op_t                      op;
		logic signed [ELEM_W-1:0] element;
	} sui_queue_t;

endpackage

// ===== rtl/sui_if.sv =====
// Input channel: one command item per handshake.
interface sui_in_if import sui_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [ELEM_W-1:0] element;

	modport source (output valid, kind, element, input ready);
	modport sink (input valid, kind, element, output ready);
endinterface

// Output channel: one result item per handshake.
interface sui_out_if import sui_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [SET_ID_W-1:0]      set_id;
	logic signed [ELEM_W-1:0] element_res;
	logic [UNION_CNT_W-1:0]   union_count;
	logic [INTER_CNT_W-1:0]   inter_count;
	logic                     done_res;

	modport source (output valid, set_id, element_res, union_count, inter_count, done_res,
		input ready);
	modport sink (input valid, set_id, element_res, union_count, inter_count, done_res,
		output ready);
endinterface

// ===== rtl/sui_front.sv =====
module sui_front import sui_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sui_in_if.sink     in,
	output sui_queue_t head,
	input  logic       pop
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	op_t                      op_q   [QUEUE_DEPTH];
	logic signed [ELEM_W-1:0] elem_q [QUEUE_DEPTH];
	logic [QW-1:0]            wr_ptr_q;
	logic [QW-1:0]            rd_ptr_q;
	logic [QW:0]              count_q;
	logic                     push;
	op_t                      in_op;

	// Accept an item whenever the queue has room.
	assign in.ready = (count_q != (QW+1)'(QUEUE_DEPTH));
	assign push     = in.valid && in.ready;

	// Classify the incoming item into an engine command.
	always_comb begin
		unique case (in.kind)
			KIND_CLEAR:    in_op = OP_CLEAR;
			KIND_APPEND_A: in_op = OP_APPEND_A;
			KIND_APPEND_B: in_op = OP_APPEND_B;
			KIND_PULL:     in_op = OP_PULL;
			default:       in_op = OP_PULL;
		endcase
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]   <= in_op;
			elem_q[wr_ptr_q] <= in.element;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QW+1)'(1);
			end
		end
	end

	// Present the oldest entry to the engine.
	assign head.valid   = (count_q != '0);
	assign head.op      = op_q[rd_ptr_q];
	assign head.element = elem_q[rd_ptr_q];

endmodule

// ===== rtl/sui_engine.sv =====
module sui_engine import sui_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  sui_queue_t head,
	output logic       pop,
	sui_out_if.source  out
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		PH_UNION_A = 2'd0,
		PH_UNION_B = 2'd1,
		PH_INTER   = 2'd2,
		PH_SUMMARY = 2'd3
	} phase_t;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_PHASE   = 7'b0000010,
		S_UA_WAIT = 7'b0000100,
		S_LOAD_B  = 7'b0001000,
		S_SCAN_A  = 7'b0010000,
		S_LOAD_A  = 7'b0100000,
		S_SCAN_B  = 7'b1000000
	} state_t;

	// Element stores.
	logic signed [ELEM_W-1:0] mem_a [DEPTH];
	logic signed [ELEM_W-1:0] mem_b [DEPTH];
	logic signed [ELEM_W-1:0] rd_a_q;
	logic signed [ELEM_W-1:0] rd_b_q;
	logic [AW-1:0]            addr_a;
	logic [AW-1:0]            addr_b;
	logic                     wr_a;
	logic                     wr_b;

	// Control state.
	state_t                 state_q, state_d;
	phase_t                 phase_q, phase_d;
	logic [CW-1:0]          size_a_q, size_a_d;
	logic [CW-1:0]          size_b_q, size_b_d;
	logic [CW-1:0]          outer_q, outer_d;
	logic [CW-1:0]          inner_q, inner_d;
	logic                   pend_q, pend_d;
	logic [UNION_CNT_W-1:0] union_q, union_d;
	logic [INTER_CNT_W-1:0] inter_q, inter_d;
	logic signed [ELEM_W-1:0] cand_q, cand_d;

	// Result output register.
	logic                     out_vld_q;
	logic [SET_ID_W-1:0]      set_id_q;
	logic signed [ELEM_W-1:0] elem_res_q;
	logic [UNION_CNT_W-1:0]   ucnt_q;
	logic [INTER_CNT_W-1:0]   icnt_q;
	logic                     done_q;
	logic                     out_free;
	logic                     emit;
	logic [SET_ID_W-1:0]      emit_id;
	logic signed [ELEM_W-1:0] emit_val;
	logic                     emit_done;
	logic [UNION_CNT_W-1:0]   union_inc;
	logic [INTER_CNT_W-1:0]   inter_inc;

	assign out_free  = !out_vld_q || out.ready;
	assign union_inc = (union_q != UNION_MAX) ? union_q + UNION_CNT_W'(1) : union_q;
	assign inter_inc = (inter_q != INTER_MAX) ? inter_q + INTER_CNT_W'(1) : inter_q;

	// Scans read at the inner cursor, everything else at the outer cursor.
	assign addr_a = (state_q == S_SCAN_A) ? inner_q[AW-1:0] : outer_q[AW-1:0];
	assign addr_b = (state_q == S_SCAN_B) ? inner_q[AW-1:0] : outer_q[AW-1:0];

	// Store A: append port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[size_a_q[AW-1:0]] <= head.element;
		end
		rd_a_q <= mem_a[addr_a];
	end

	// Store B: append port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[size_b_q[AW-1:0]] <= head.element;
		end
		rd_b_q <= mem_b[addr_b];
	end

	// Command execution and scan sequencer.
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		size_a_d  = size_a_q;
		size_b_d  = size_b_q;
		outer_d   = outer_q;
		inner_d   = inner_q;
		pend_d    = pend_q;
		union_d   = union_q;
		inter_d   = inter_q;
		cand_d    = cand_q;
		pop       = 1'b0;
		wr_a      = 1'b0;
		wr_b      = 1'b0;
		emit      = 1'b0;
		emit_id   = ID_UNION;
		emit_val  = '0;
		emit_done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					unique case (head.op)
						OP_CLEAR: begin
							pop      = 1'b1;
							size_a_d = '0;
							size_b_d = '0;
							phase_d  = PH_UNION_A;
							outer_d  = '0;
							inner_d  = '0;
							union_d  = '0;
							inter_d  = '0;
						end
						OP_APPEND_A: begin
							pop = 1'b1;
							if (size_a_q < CW'(DEPTH)) begin
								wr_a     = 1'b1;
								size_a_d = size_a_q + CW'(1);
							end
						end
						OP_APPEND_B: begin
							pop = 1'b1;
							if (size_b_q < CW'(DEPTH)) begin
								wr_b     = 1'b1;
								size_b_d = size_b_q + CW'(1);
							end
						end
						OP_PULL: begin
							// A pull starts only when its result is sure to find room.
							if (out_free) begin
								pop     = 1'b1;
								state_d = S_PHASE;
							end
						end
						default: ;
					endcase
				end
			end
			S_PHASE: begin
				unique case (phase_q)
					PH_UNION_A: begin
						if (outer_q < size_a_q) begin
							state_d = S_UA_WAIT;
						end else begin
							phase_d = PH_UNION_B;
							outer_d = '0;
						end
					end
					PH_UNION_B: begin
						if (outer_q < size_b_q) begin
							state_d = S_LOAD_B;
						end else begin
							phase_d = PH_INTER;
							outer_d = '0;
							inner_d = '0;
						end
					end
					PH_INTER: begin
						if (outer_q < size_a_q) begin
							state_d = S_LOAD_A;
						end else begin
							phase_d = PH_SUMMARY;
							outer_d = '0;
							inner_d = '0;
						end
					end
					PH_SUMMARY: begin
						emit      = 1'b1;
						emit_id   = ID_SUMMARY;
						emit_done = 1'b1;
						state_d   = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_UA_WAIT: begin
				outer_d  = outer_q + CW'(1);
				union_d  = union_inc;
				emit     = 1'b1;
				emit_val = rd_a_q;
				state_d  = S_IDLE;
			end
			S_LOAD_B: begin
				cand_d  = rd_b_q;
				outer_d = outer_q + CW'(1);
				inner_d = '0;
				pend_d  = 1'b0;
				state_d = S_SCAN_A;
			end
			S_SCAN_A: begin
				// One compare per cycle against the read issued the cycle before.
				if (pend_q && (rd_a_q == cand_q)) begin
					state_d = S_PHASE;
				end else if (inner_q < size_a_q) begin
					inner_d = inner_q + CW'(1);
					pend_d  = 1'b1;
				end else begin
					union_d  = union_inc;
					emit     = 1'b1;
					emit_val = cand_q;
					state_d  = S_IDLE;
				end
			end
			S_LOAD_A: begin
				cand_d  = rd_a_q;
				pend_d  = 1'b0;
				state_d = S_SCAN_B;
			end
			S_SCAN_B: begin
				// The inner cursor is kept across pulls so the scan resumes after a match.
				if (pend_q && (rd_b_q == cand_q)) begin
					inter_d  = inter_inc;
					emit     = 1'b1;
					emit_id  = ID_INTER;
					emit_val = cand_q;
					state_d  = S_IDLE;
				end else if (inner_q < size_b_q) begin
					inner_d = inner_q + CW'(1);
					pend_d  = 1'b1;
				end else begin
					outer_d = outer_q + CW'(1);
					inner_d = '0;
					state_d = S_PHASE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_UNION_A;
			size_a_q  <= '0;
			size_b_q  <= '0;
			outer_q   <= '0;
			inner_q   <= '0;
			pend_q    <= 1'b0;
			union_q   <= '0;
			inter_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			size_a_q <= size_a_d;
			size_b_q <= size_b_d;
			outer_q  <= outer_d;
			inner_q  <= inner_d;
			pend_q   <= pend_d;
			union_q  <= union_d;
			inter_q  <= inter_d;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Scan candidate and result payload.
	always_ff @(posedge clk) begin
		cand_q <= cand_d;
		if (emit) begin
			set_id_q   <= emit_id;
			elem_res_q <= emit_val;
			ucnt_q     <= union_d;
			icnt_q     <= inter_d;
			done_q     <= emit_done;
		end
	end

	assign out.valid       = out_vld_q;
	assign out.set_id      = set_id_q;
	assign out.element_res = elem_res_q;
	assign out.union_count = ucnt_q;
	assign out.inter_count = icnt_q;
	assign out.done_res    = done_q;

endmodule

// ===== rtl/set_union_intersection_unit.sv =====
// Clear and append items produce no result. A pull of a union-of-A element passes through
// the phase and wait states before its result is registered; a pull scans store A for each
// B element (union of B) and store B for each A element (intersection), one element compare
// per cycle on the single read port of each store.
// Reset clears sizes, cursors, counts, phase and queue; the stores are not cleared.
module set_union_intersection_unit import sui_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sui_in_if.sink    in,
	sui_out_if.source out
);

	sui_queue_t head;
	logic       pop;

	// Front: accepts and classifies items into a short queue.
	sui_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.head   (head),
		.pop    (pop)
	);

	// Engine: stores, scan sequencer and result register.
	sui_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out    (out)
	);

`ifndef SYNTHESIS
	// A queued item stays until the engine takes it.
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid && !pop |=> head.valid)
		else $error("queued item lost without pop");

	// The engine takes only items that are present.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from an empty queue");

	// A pull starts only when the result register is free or draining.
	a_pull_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op == OP_PULL |-> !out.valid || out.ready)
		else $error("pull started while the result register is blocked");

	// The summary result is marked done and carries no element.
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.set_id == ID_SUMMARY |-> out.done_res && out.element_res == '0)
		else $error("malformed summary result");
`endif

endmodule

// ===== tb/sv/set_union_intersection_unit_checker.sv =====
`timescale 1ns / 100ps

module set_union_intersection_unit_checker import sui_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sui_in_if    cmd_if,
	sui_out_if   res_if,
	output int   errors,
	output int   pending,
	output int   checked
);

	// Where the scan of the two lists currently stands.
	typedef enum logic [1:0] {
		SCAN_UNION_A,
		SCAN_UNION_B,
		SCAN_INTER,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic [SET_ID_W-1:0]      set_id;
		logic signed [ELEM_W-1:0] element;
		logic [UNION_CNT_W-1:0]   union_count;
		logic [INTER_CNT_W-1:0]   inter_count;
		logic                     done;
	} set_result_t;

	// Shadow copy of both lists, the scan position and the running counts.
	logic signed [ELEM_W-1:0] list_a [DEPTH];
	logic signed [ELEM_W-1:0] list_b [DEPTH];
	int unsigned              len_a;
	int unsigned              len_b;
	int unsigned              pos_outer;
	int unsigned              pos_inner;
	scan_phase_t              scan;
	logic [UNION_CNT_W-1:0]   union_seen;
	logic [INTER_CNT_W-1:0]   inter_seen;

	set_result_t expected_results [$];
	int          mismatch_count;
	int          checked_count;

	task automatic report_mismatch(string msg);
		if (mismatch_count < 50) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Empties both lists and restarts the scan; the list contents stay as they are.
	task automatic empty_lists();
		len_a = 0;
		len_b = 0;
		pos_outer = 0;
		pos_inner = 0;
		scan = SCAN_UNION_A;
		union_seen = '0;
		inter_seen = '0;
	endtask

	function automatic bit held_in_a(logic signed [ELEM_W-1:0] value);
		for (int i = 0; i < len_a; i++) begin
			if (list_a[i] == value) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic set_result_t make_result(logic [SET_ID_W-1:0] set_id,
		logic signed [ELEM_W-1:0] value, logic done);
		set_result_t r;
		r.set_id = set_id;
		r.element = value;
		r.union_count = union_seen;
		r.inter_count = inter_seen;
		r.done = done;
		return r;
	endfunction

	// Advances the scan to the next union or intersection element, or the summary.
	function automatic set_result_t next_set_result();
		logic signed [ELEM_W-1:0] value;
		logic signed [ELEM_W-1:0] other;
		if (scan == SCAN_UNION_A) begin
			if (pos_outer < len_a) begin
				value = list_a[pos_outer];
				pos_outer++;
				if (union_seen != UNION_MAX) union_seen++;
				return make_result(ID_UNION, value, 1'b0);
			end
			scan = SCAN_UNION_B;
			pos_outer = 0;
		end
		if (scan == SCAN_UNION_B) begin
			while (pos_outer < len_b) begin
				value = list_b[pos_outer];
				pos_outer++;
				if (!held_in_a(value)) begin
					if (union_seen != UNION_MAX) union_seen++;
					return make_result(ID_UNION, value, 1'b0);
				end
			end
			scan = SCAN_INTER;
			pos_outer = 0;
			pos_inner = 0;
		end
		if (scan == SCAN_INTER) begin
			// A-major: every B entry equal to the current A entry yields one element.
			while (pos_outer < len_a) begin
				value = list_a[pos_outer];
				while (pos_inner < len_b) begin
					other = list_b[pos_inner];
					pos_inner++;
					if (value == other) begin
						if (inter_seen != INTER_MAX) inter_seen++;
						return make_result(ID_INTER, value, 1'b0);
					end
				end
				pos_outer++;
				pos_inner = 0;
			end
			pos_outer = 0;
			pos_inner = 0;
		end
		scan = SCAN_DONE;
		return make_result(ID_SUMMARY, '0, 1'b1);
	endfunction

	task automatic take_command(logic [KIND_W-1:0] kind, logic signed [ELEM_W-1:0] element);
		case (kind)
			KIND_CLEAR: begin
				empty_lists();
			end
			KIND_APPEND_A: begin
				if (len_a < DEPTH) begin
					list_a[len_a] = element;
					len_a++;
				end
			end
			KIND_APPEND_B: begin
				if (len_b < DEPTH) begin
					list_b[len_b] = element;
					len_b++;
				end
			end
			default: begin
				expected_results.push_back(next_set_result());
			end
		endcase
	endtask

	task automatic compare_result();
		set_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result (set_id %0d, element %h) with no pull waiting",
				res_if.set_id, res_if.element_res));
			return;
		end
		want = expected_results.pop_front();
		checked_count++;
		if (res_if.set_id !== want.set_id) begin
			report_mismatch($sformatf("result %0d set_id %0d, expected %0d",
				checked_count, res_if.set_id, want.set_id));
		end
		if (res_if.element_res !== want.element) begin
			report_mismatch($sformatf("result %0d element_res %h, expected %h",
				checked_count, res_if.element_res, want.element));
		end
		if (res_if.union_count !== want.union_count) begin
			report_mismatch($sformatf("result %0d union_count %0d, expected %0d",
				checked_count, res_if.union_count, want.union_count));
		end
		if (res_if.inter_count !== want.inter_count) begin
			report_mismatch($sformatf("result %0d inter_count %0d, expected %0d",
				checked_count, res_if.inter_count, want.inter_count));
		end
		if (res_if.done_res !== want.done) begin
			report_mismatch($sformatf("result %0d done_res %b, expected %b",
				checked_count, res_if.done_res, want.done));
		end
	endtask

	// Commands are applied before results are checked, since a result always trails its pull.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_lists();
			expected_results.delete();
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				take_command(cmd_if.kind, cmd_if.element);
			end
			if (res_if.valid && res_if.ready) begin
				compare_result();
			end
		end
		errors <= mismatch_count;
		pending <= expected_results.size();
		checked <= checked_count;
	end

endmodule

// ===== tb/sv/set_union_intersection_unit_tb.sv =====
`timescale 1ns / 100ps

module set_union_intersection_unit_tb;
	import sui_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int IDLE_PCT = 21;
	localparam int RANDOM_ITEMS = 1000;

	logic clk;
	logic arst_n;

	sui_in_if  cmd_if ();
	sui_out_if res_if ();

	int errors;
	int pending;
	int checked;

	// Stimulus bookkeeping; budget grows with the scan work each item can cause.
	int          cycles;
	int          budget;
	int          sent;
	int          pulls;
	int          appends;
	int          dropped;
	int          clears;
	int          summaries;
	int unsigned size_a;
	int unsigned size_b;
	bit          quiet;

	set_union_intersection_unit #(
		.DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (cmd_if),
		.out   (res_if)
	);

	set_union_intersection_unit_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_if (cmd_if),
		.res_if (res_if),
		.errors (errors),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: stalls at random except during the quiet stretch.
	always @(posedge clk) begin
		res_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Cycle count, finished scans, and the timeout.
	always @(posedge clk) begin
		cycles++;
		if (res_if.valid && res_if.ready && res_if.done_res) begin
			summaries++;
		end
		if (cycles > 8 * budget + 50000) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Presents one command item, idling at random first, and returns once it is accepted.
	task automatic send_item(logic [KIND_W-1:0] kind, logic signed [ELEM_W-1:0] element);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		budget += 16;
		case (kind)
			KIND_CLEAR: begin
				size_a = 0;
				size_b = 0;
				clears++;
			end
			KIND_APPEND_A: begin
				appends++;
				if (size_a < DEPTH) size_a++;
				else dropped++;
			end
			KIND_APPEND_B: begin
				appends++;
				if (size_b < DEPTH) size_b++;
				else dropped++;
			end
			default: begin
				pulls++;
				budget += 2 * (size_a + 4) * (size_b + 4);
			end
		endcase
		cmd_if.valid <= 1'b1;
		cmd_if.kind <= kind;
		cmd_if.element <= element;
		do begin
			@(posedge clk);
		end while (!cmd_if.ready);
		sent++;
	endtask

	// Withdraws the input and waits until every pull has its result.
	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// A value from a small shared pool with pool_pct percent chance, so that the lists overlap and repeat.
	function automatic logic signed [ELEM_W-1:0] draw_element(
		input logic signed [ELEM_W-1:0] pool [8], input int pool_n, input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct) begin
			return pool[$urandom_range(0, pool_n - 1)];
		end
		return $urandom;
	endfunction

	initial begin
		logic signed [ELEM_W-1:0] pool [8];
		int                       pool_n;
		int                       pool_pct;
		int                       n_a;
		int                       n_b;
		int                       seen_before;
		int                       stop_at;
		int                       n_pull;
		int                       random_start;
		bit                       big_lists;

		arst_n <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.kind <= KIND_CLEAR;
		cmd_if.element <= '0;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty lists: the summary comes at once and again on the next pull.
		send_item(KIND_CLEAR, '0);
		send_item(KIND_PULL, '1);
		send_item(KIND_PULL, '0);
		send_item(KIND_CLEAR, 32'sh7FFF_FFFF);

		// Extreme values, an overlap and a duplicate in B.
		send_item(KIND_APPEND_A, 32'sh7FFF_FFFF);
		send_item(KIND_APPEND_A, 32'sh8000_0000);
		send_item(KIND_APPEND_A, 32'sh0000_0000);
		send_item(KIND_APPEND_A, -32'sd1);
		send_item(KIND_APPEND_B, -32'sd1);
		send_item(KIND_APPEND_B, 32'sh8000_0000);
		send_item(KIND_APPEND_B, 32'sd5);
		send_item(KIND_APPEND_B, -32'sd1);

		// Walk the whole scan, with an append to B after the scan of B has begun.
		for (int i = 0; i < 12; i++) begin
			if (i == 5) begin
				send_item(KIND_APPEND_B, 32'sd0);
			end
			send_item(KIND_PULL, $urandom);
		end
		wait_drained();

		// Random lists: mostly small, now and then filled past capacity.
		random_start = sent - dropped;
		while (sent - dropped - random_start < RANDOM_ITEMS) begin
			quiet = (sent - random_start > 400) && (sent - random_start < 650);
			big_lists = ($urandom_range(0, 14) == 0);
			pool_n = big_lists ? 2 : $urandom_range(1, 8);
			pool_pct = big_lists ? 10 : 75;
			for (int i = 0; i < 8; i++) begin
				pool[i] = $urandom;
			end
			n_a = big_lists ? $urandom_range(DEPTH - 4, DEPTH + 4) : $urandom_range(0, 8);
			n_b = big_lists ? $urandom_range(DEPTH - 4, DEPTH + 4) : $urandom_range(0, 8);

			// A few short bursts of arbitrary commands.
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 10)) begin
					send_item(KIND_W'($urandom_range(0, 3)),
						draw_element(pool, pool_n, pool_pct));
				end
				wait_drained();
			end

			// Occasionally the old lists are kept and the new elements added to them.
			if ($urandom_range(0, 9) != 0) begin
				send_item(KIND_CLEAR, $urandom);
			end
			while (n_a + n_b > 0) begin
				if (n_b == 0 || (n_a != 0 && $urandom_range(0, 1) == 1)) begin
					send_item(KIND_APPEND_A, draw_element(pool, pool_n, pool_pct));
					n_a--;
				end else begin
					send_item(KIND_APPEND_B, draw_element(pool, pool_n, pool_pct));
					n_b--;
				end
			end

			// Pull until a summary comes back, or stop early to leave a scan unfinished.
			seen_before = summaries;
			stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : -1;
			n_pull = 0;
			while (summaries == seen_before && n_pull != stop_at && n_pull < 5000) begin
				if ($urandom_range(0, 11) == 0) begin
					send_item($urandom_range(0, 1) ? KIND_APPEND_A : KIND_APPEND_B,
						draw_element(pool, pool_n, pool_pct));
				end else begin
					send_item(KIND_PULL, $urandom);
					n_pull++;
				end
			end
			wait_drained();
		end

		wait_drained();
		repeat (32) @(posedge clk);

		$display("Run covered %0d items: %0d pulls, %0d clears, %0d appends (%0d dropped as full).",
			sent, pulls, clears, appends, dropped);
		$display("Compared %0d results; %0d summaries returned, %0d cycles.",
			checked, summaries, cycles);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== set_union_intersection_unit.f =====
rtl/sui_pkg.sv
rtl/sui_if.sv
rtl/sui_front.sv
rtl/sui_engine.sv
rtl/set_union_intersection_unit.sv
tb/sv/set_union_intersection_unit_checker.sv
tb/sv/set_union_intersection_unit_tb.sv
